>>> sv/ieu_pkg.sv
// Package for the incremental entropy update block: payload structs,
// controller/datapath command and status types, constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ieu_pkg;
    localparam int NUM_TASKS_DEF  = 32;
    localparam int COUNT_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int ENT_W          = 22;
    localparam int TOT_W          = 32;
    localparam int IDX_W          = 5;
    localparam int ADD_W          = 16;
    localparam logic [ENT_W-1:0] ENT_MAX = '1;

    typedef struct packed {
        logic [IDX_W-1:0] task_index;
        logic [ADD_W-1:0] added_count;
        logic             first_of_set;
    } in_item_t;

    typedef struct packed {
        logic [ENT_W-1:0] entropy_bits;
        logic [TOT_W-1:0] new_total;
        logic             saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_CLEAR, ST_READ, ST_SUM, ST_LOG, ST_MUL, ST_ACC,
        ST_DSTART, ST_DIV, ST_FIN
    } state_t;

    // log operand select
    typedef enum logic [1:0] {LS_N, LS_NN, LS_G, LS_F} lsel_t;
    // product select
    typedef enum logic [1:0] {MS_LN, MS_TG, MS_HN, MS_TF} msel_t;

    typedef struct packed {
        logic  load;
        logic  clr_step;
        logic  read;
        logic  sum;
        logic  log_start;
        lsel_t lsel;
        logic  mul;
        msel_t msel;
        logic  acc;
        logic  div_start;
        logic  fin;
        logic  commit;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic n_zero;
        logic log_done;
        logic div_done;
    } sts_t;
endpackage
`default_nettype wire

>>> sv/ieu_ctrl.sv
// Controller for the incremental entropy update block.
// Sequences clear, read, log2, products, division and result. Uses ieu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ieu_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    input  wire                first_of_set,
    output logic               in_ready,
    output logic               out_valid,
    input  wire                out_ready,
    output ieu_pkg::cmd_t      cmd,
    input  ieu_pkg::sts_t      sts
);
    import ieu_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] step_reg, step_next;
    logic out_full_reg, out_full_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            step_reg     <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            out_full_reg <= out_full_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        out_full_next = out_full_reg;
        if (out_full_reg && out_ready)
            out_full_next = 1'b0;
        cmd        = '0;
        cmd.lsel   = lsel_t'(step_reg);
        cmd.msel   = msel_t'(step_reg);
        in_ready   = 1'b0;
        out_valid  = out_full_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = first_of_set ? ST_CLEAR : ST_READ;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                step_next  = '0;
                state_next = sts.n_zero ? ST_FIN : ST_LOG;
                cmd.log_start = !sts.n_zero;
                cmd.lsel   = LS_N;
            end
            ST_LOG:
            begin
                if (sts.log_done)
                begin
                    if (step_reg == 2'd1)
                    begin
                        cmd.log_start = 1'b1;
                        cmd.lsel      = LS_G;
                        step_next     = 2'd2;
                    end
                    else if (step_reg == 2'd3)
                    begin
                        step_next  = '0;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        cmd.log_start = 1'b1;
                        cmd.lsel      = lsel_t'(step_reg + 2'd1);
                        step_next     = step_reg + 2'd1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (step_reg == 2'd3)
                    state_next = ST_DSTART;
                else
                begin
                    step_next  = step_reg + 2'd1;
                    state_next = ST_MUL;
                end
            end
            ST_DSTART:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait for the result register to free up
                if (!out_full_reg || out_ready)
                begin
                    cmd.fin       = 1'b1;
                    cmd.commit    = 1'b1;
                    out_full_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

>>> sv/ieu_datapath.sv
// Datapath for the incremental entropy update block: count table, total,
// bit-serial log2, shared multiplier, accumulator and restoring divider. Uses ieu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ieu_datapath #(
    parameter int NUM_TASKS  = ieu_pkg::NUM_TASKS_DEF,
    parameter int COUNT_BITS = ieu_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = ieu_pkg::FRAC_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ieu_pkg::in_item_t   in_item,
    input  ieu_pkg::cmd_t       cmd,
    output ieu_pkg::sts_t       sts,
    output ieu_pkg::out_item_t  out_item
);
    import ieu_pkg::*;

    localparam int TI_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int NB_W  = $clog2(COUNT_BITS);
    localparam int LOG_W = NB_W + FRAC_BITS;
    localparam int MB_W  = (LOG_W > ENT_W) ? LOG_W : ENT_W;
    localparam int PRD_W = COUNT_BITS + MB_W;
    localparam int ACC_W = PRD_W + 2;
    localparam int QCAP  = 40;
    localparam int Q_W   = QCAP + 1;
    localparam int DC_W  = $clog2(ACC_W + 1);
    localparam int FC_W  = $clog2(FRAC_BITS + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam logic [Q_W-1:0] QLIM = Q_W'(1) << QCAP;

    logic [COUNT_BITS-1:0] cnt_mem [NUM_TASKS];
    logic [TI_W-1:0] clr_reg;
    logic [TI_W-1:0] idx_reg;
    logic [ADD_W-1:0] e_reg;
    logic [COUNT_BITS-1:0] tot_reg, n_reg, f_reg, g_reg, nn_reg, rd_reg;
    logic [ENT_W-1:0] ent_reg, h_reg;
    logic [TOT_W-1:0] tot_out_reg;
    logic sat_reg, sat_out_reg;

    // index wraps modulo NUM_TASKS, as a constant table
    function automatic logic [TI_W-1:0] wrap_index(input logic [IDX_W-1:0] ti);
        logic [TI_W-1:0] r;
        r = '0;
        for (int k = 0; k < 2**IDX_W; k++)
            if (ti == IDX_W'(k))
                r = TI_W'(k % NUM_TASKS);
        return r;
    endfunction

    logic [TI_W-1:0] idx_wrap;
    assign idx_wrap = wrap_index(in_item.task_index);

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            cnt_mem[clr_reg] <= '0;
        else if (cmd.commit)
            cnt_mem[idx_reg] <= g_reg;
        if (cmd.read)
            rd_reg <= cnt_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clr_step)
            clr_reg <= (32'(clr_reg) == NUM_TASKS - 1) ? '0 : clr_reg + 1'b1;
    end
    assign sts.clr_done = cmd.clr_step && (32'(clr_reg) == NUM_TASKS - 1);

    // sums with saturation
    logic [COUNT_BITS:0] nn_sum, g_sum;
    assign nn_sum = {1'b0, n_reg} + (COUNT_BITS+1)'(e_reg);
    assign g_sum  = {1'b0, rd_reg} + (COUNT_BITS+1)'(e_reg);

    // log2 unit: normalize then one fraction bit per cycle
    logic [COUNT_BITS-1:0] lx_reg;
    logic [NB_W-1:0] lexp_reg;
    logic [32:0] m_reg;
    logic [FC_W-1:0] lcnt_reg;
    logic [FRAC_BITS-1:0] lfrac_reg;
    logic lbusy_reg, lnorm_reg;
    logic [LOG_W-1:0] lg_n, lg_nn, lg_g, lg_f;
    logic [1:0] lsel_reg;
    logic [65:0] sq;
    logic [33:0] msq;
    assign sq  = m_reg * m_reg;
    assign msq = 34'(sq >> 31);

    logic [COUNT_BITS-1:0] lsrc;
    always_comb
    begin
        unique case (cmd.lsel)
            LS_N:    lsrc = n_reg;
            LS_NN:   lsrc = (n_reg == '0) ? nn_sum[COUNT_BITS-1:0] : nn_reg;
            LS_G:    lsrc = g_reg;
            default: lsrc = f_reg;
        endcase
    end

    logic [NB_W-1:0] msb;
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < COUNT_BITS; i++)
            if (lx_reg[i])
                msb = NB_W'(i);
    end

    logic [LOG_W-1:0] lres;
    assign lres = {lexp_reg, lfrac_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lbusy_reg <= 1'b0;
            lnorm_reg <= 1'b0;
        end
        else if (cmd.log_start)
        begin
            lbusy_reg <= 1'b1;
            lnorm_reg <= 1'b1;
        end
        else if (lnorm_reg)
            lnorm_reg <= 1'b0;
        else if (lbusy_reg && lcnt_reg == '0)
            lbusy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.log_start)
        begin
            lx_reg   <= lsrc;
            lsel_reg <= cmd.lsel;
        end
        else if (lnorm_reg)
        begin
            lexp_reg  <= msb;
            lfrac_reg <= '0;
            lcnt_reg  <= FC_W'(FRAC_BITS);
            if (32'(msb) >= 31)
                m_reg <= 33'(lx_reg >> (32'(msb) - 31));
            else
                m_reg <= 33'(lx_reg) << (31 - 32'(msb));
        end
        else if (lbusy_reg && lcnt_reg != '0)
        begin
            lcnt_reg  <= lcnt_reg - 1'b1;
            lfrac_reg <= {lfrac_reg[FRAC_BITS-2:0], msq[32] | msq[33]};
            m_reg     <= (msq[33] | msq[32]) ? 33'(msq >> 1) : msq[32:0];
        end
        // store the finished log even when the next run starts this cycle
        if (sts.log_done)
        begin
            unique case (lsel_reg)
                LS_N:    lg_n  <= (lx_reg == '0) ? '0 : lres;
                LS_NN:   lg_nn <= (lx_reg == '0) ? '0 : lres;
                LS_G:    lg_g  <= (lx_reg == '0) ? '0 : lres;
                default: lg_f  <= (lx_reg == '0) ? '0 : lres;
            endcase
        end
    end
    assign sts.log_done = lbusy_reg && !lnorm_reg && lcnt_reg == '0;

    // shared multiplier, registered product
    logic [COUNT_BITS-1:0] ma;
    logic [MB_W-1:0] mb;
    logic [PRD_W-1:0] prd_reg;
    always_comb
    begin
        unique case (cmd.msel)
            MS_LN:   begin ma = n_reg; mb = MB_W'(lg_n); end
            MS_TG:   begin ma = g_reg; mb = MB_W'(lg_g); end
            MS_HN:   begin ma = n_reg; mb = MB_W'(ent_reg); end
            default: begin ma = f_reg; mb = MB_W'(lg_f); end
        endcase
    end

    logic [ACC_W-1:0] pos_reg, neg_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.mul)
            prd_reg <= PRD_W'(ma * mb);
        if (cmd.sum)
        begin
            pos_reg <= '0;
            neg_reg <= '0;
        end
        else if (cmd.acc)
        begin
            if (cmd.msel == MS_LN || cmd.msel == MS_TG)
                pos_reg <= pos_reg + ACC_W'(prd_reg);
            else
                neg_reg <= neg_reg + ACC_W'(prd_reg);
        end
    end

    // restoring divider, one quotient bit per cycle
    logic [ACC_W-1:0] dn_reg;
    logic [COUNT_BITS:0] rem_reg;
    logic [Q_W-1:0] q_reg;
    logic qov_reg, neg_flag_reg, dbusy_reg;
    logic [DC_W-1:0] dcnt_reg;
    logic [COUNT_BITS+1:0] rtry;
    logic [COUNT_BITS+1:0] rsub;
    assign rtry = {rem_reg, dn_reg[ACC_W-1]};
    assign rsub = rtry - (COUNT_BITS+2)'(nn_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dbusy_reg <= 1'b0;
        else if (cmd.div_start)
            dbusy_reg <= 1'b1;
        else if (dbusy_reg && dcnt_reg == '0)
            dbusy_reg <= 1'b0;
    end
    assign sts.div_done = dbusy_reg && dcnt_reg == '0;

    logic negative;
    assign negative = pos_reg < neg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_flag_reg <= negative;
            dn_reg   <= negative ? neg_reg - pos_reg : pos_reg - neg_reg;
            rem_reg  <= '0;
            q_reg    <= '0;
            qov_reg  <= 1'b0;
            dcnt_reg <= DC_W'(ACC_W);
        end
        else if (dbusy_reg && dcnt_reg != '0)
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
            dn_reg   <= dn_reg << 1;
            if (!rsub[COUNT_BITS+1])
            begin
                rem_reg <= rsub[COUNT_BITS:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                qov_reg <= qov_reg | q_reg[Q_W-1];
            end
            else
            begin
                rem_reg <= rtry[COUNT_BITS:0];
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                qov_reg <= qov_reg | q_reg[Q_W-1];
            end
        end
    end

    logic [Q_W-1:0] qv;
    assign qv = (qov_reg || q_reg > QLIM) ? QLIM : q_reg;
    logic [Q_W+1:0] res_pos, res_sub;
    assign res_pos = (Q_W+2)'(lg_nn) + (Q_W+2)'(qv);
    assign res_sub = (Q_W+2)'(lg_nn) - (Q_W+2)'(qv);

    logic [ENT_W-1:0] h_calc;
    always_comb
    begin
        if (n_reg == '0)
            h_calc = '0;
        else if (neg_flag_reg)
            h_calc = (res_pos > (Q_W+2)'(ENT_MAX)) ? ENT_MAX : ENT_W'(res_pos);
        else if (res_sub[Q_W+1])
            h_calc = '0;
        else
            h_calc = (res_sub > (Q_W+2)'(ENT_MAX)) ? ENT_MAX : ENT_W'(res_sub);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tot_reg <= '0;
            ent_reg <= '0;
        end
        else if (cmd.clr_step && 32'(clr_reg) == 0)
        begin
            tot_reg <= '0;
            ent_reg <= '0;
        end
        else if (cmd.commit)
        begin
            tot_reg <= nn_reg;
            ent_reg <= h_calc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg <= idx_wrap;
            e_reg   <= in_item.added_count;
        end
        if (cmd.read)
            n_reg <= tot_reg;
        if (cmd.sum)
        begin
            f_reg   <= rd_reg;
            nn_reg  <= nn_sum[COUNT_BITS] ? CMAX : nn_sum[COUNT_BITS-1:0];
            g_reg   <= g_sum[COUNT_BITS] ? CMAX : g_sum[COUNT_BITS-1:0];
            sat_reg <= nn_sum[COUNT_BITS] | g_sum[COUNT_BITS];
        end
        if (cmd.fin)
        begin
            h_reg       <= h_calc;
            tot_out_reg <= (COUNT_BITS > TOT_W && (nn_reg >> TOT_W) != '0) ?
                           '1 : TOT_W'(nn_reg);
            sat_out_reg <= sat_reg;
        end
    end
    assign sts.n_zero = (n_reg == '0);

    assign out_item.entropy_bits = h_reg;
    assign out_item.new_total    = tot_out_reg;
    assign out_item.saturated    = sat_out_reg;
endmodule
`default_nettype wire

>>> sv/incremental_entropy_update.sv
// Incremental entropy update block, top level. Instantiates ieu_ctrl and
// ieu_datapath; uses ieu_pkg.
//
// Input channel in_valid/in_ready carries {task_index, added_count,
// first_of_set}; output channel out_valid/out_ready carries {entropy_bits,
// new_total, saturated}. One result per item, in order.
// One item at a time: in_ready is high only while the controller is idle.
// Order of work after the input transfer: read and sum, four log2 runs,
// four multiply and accumulate pairs, divider load, the restoring divider
// over the ACC_W-bit dividend (ACC_W = COUNT_BITS+max(LOG_W,22)+2), and
// commit. When the previous total is zero the log2, product and divider
// steps are skipped. The next item can be taken the same cycle the result
// goes up.
// A first_of_set item first sweeps the count table.
// Reset clears the total, entropy and control state, then sweeps the table
// with in_ready low.
// A stalled receiver holds the result in its register; the next item is
// still worked and waits before commit until that result transfers.
`timescale 1ns / 1ps
`default_nettype none
module incremental_entropy_update #(
    parameter int NUM_TASKS  = ieu_pkg::NUM_TASKS_DEF,
    parameter int COUNT_BITS = ieu_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = ieu_pkg::FRAC_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  ieu_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output ieu_pkg::out_item_t  out_data
);
    import ieu_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ieu_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .first_of_set (in_data.first_of_set),
        .in_ready     (in_ready),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    ieu_datapath #(
        .NUM_TASKS  (NUM_TASKS),
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_data)
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
    a_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("commit not followed by result");
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");
endmodule
`default_nettype wire

>>> tb/incremental_entropy_update_tb.sv
// Testbench for incremental_entropy_update: directed table, then random transfers,
// checked field by field against typed rows or a built-in predictor. Uses ieu_pkg.
`timescale 1ns / 1ps
module incremental_entropy_update_tb;
    import ieu_pkg::*;

    localparam int      NTASK      = NUM_TASKS_DEF;
    localparam int      RAND_ITEMS = 630;
    localparam int      DRAIN      = 400;
    localparam longint  CYCLE_CAP  = 1000000;
    localparam logic [63:0] CNT_MAX = 64'hFFFF_FFFF;
    localparam logic [63:0] Q_CAP   = 64'h100_0000_0000;

    typedef struct {
        int          idx;
        int          add;
        bit          fos;
        bit          typed;
        logic [21:0] ent;
        logic [31:0] tot;
    } row_t;

    logic      clk, rst_n, in_valid, in_ready, out_valid, out_ready;
    in_item_t  in_data;
    out_item_t out_data;

    logic [63:0] task_cnt [NTASK];
    logic [63:0] total_cnt;
    logic [63:0] entropy_q;
    out_item_t   expected_results [$];
    int          errors;
    int          send_idle_pct, recv_stall_pct;
    longint      cycles;

    incremental_entropy_update dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [63:0] log2_q16(logic [63:0] x);
        int          msb;
        logic [63:0] m, r;
        if (x == 0)
            return 0;
        msb = 63;
        while (!x[msb])
            msb--;
        m = (msb >= 31) ? (x >> (msb - 31)) : (x << (31 - msb));
        r = 64'(msb) << 16;
        for (int k = 15; k >= 0; k--)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                r[k] = 1'b1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

    function automatic out_item_t predict_entropy(in_item_t it);
        int           idx;
        logic [63:0]  e, n, f, g, nn, h, qv;
        logic [127:0] pos, neg, mag, q;
        logic         sat, negative;
        longint       res;
        out_item_t    r;
        idx = int'(it.task_index) % NTASK;
        e   = 64'(it.added_count);
        sat = 1'b0;
        h   = 0;
        if (it.first_of_set)
        begin
            foreach (task_cnt[i])
                task_cnt[i] = 0;
            total_cnt = 0;
            entropy_q = 0;
        end
        n  = total_cnt;
        f  = task_cnt[idx];
        nn = n + e;
        if (nn > CNT_MAX)
        begin
            nn  = CNT_MAX;
            sat = 1'b1;
        end
        g = f + e;
        if (g > CNT_MAX)
        begin
            g   = CNT_MAX;
            sat = 1'b1;
        end
        if (n != 0)
        begin
            pos = 128'(log2_q16(n)) * 128'(n) + 128'(g) * 128'(log2_q16(g));
            neg = 128'(entropy_q) * 128'(n) + 128'(f) * 128'(log2_q16(f));
            negative = pos < neg;
            mag = negative ? neg - pos : pos - neg;
            q   = mag / 128'(nn);
            qv  = (q > 128'(Q_CAP)) ? Q_CAP : q[63:0];
            res = negative ? longint'(log2_q16(nn)) + longint'(qv)
                           : longint'(log2_q16(nn)) - longint'(qv);
            if (res < 0)
                res = 0;
            if (res > longint'(ENT_MAX))
                res = longint'(ENT_MAX);
            h = 64'(res);
        end
        task_cnt[idx] = g;
        total_cnt     = nn;
        entropy_q     = h;
        r.entropy_bits = h[21:0];
        r.new_total    = nn[31:0];
        r.saturated    = sat;
        return r;
    endfunction

    // one transfer; valid stays high across back-to-back items
    task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
        out_item_t p;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p = predict_entropy(it);
        expected_results.insert(expected_results.size(), typed ? typed_res : p);
    endtask

    always @(posedge clk)
    begin
        out_item_t x;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, out_data);
                errors++;
            end
            else
            begin
                x = expected_results.pop_front();
                if (out_data.entropy_bits !== x.entropy_bits)
                begin
                    $display("%0t: entropy_bits exp %0d got %0d", $time,
                             x.entropy_bits, out_data.entropy_bits);
                    errors++;
                end
                if (out_data.new_total !== x.new_total)
                begin
                    $display("%0t: new_total exp %0d got %0d", $time,
                             x.new_total, out_data.new_total);
                    errors++;
                end
                if (out_data.saturated !== x.saturated)
                begin
                    $display("%0t: saturated exp %0d got %0d", $time,
                             x.saturated, out_data.saturated);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_CAP)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        row_t      dir [$];
        in_item_t  it;
        out_item_t tr;
        int        hot;
        errors = 0;
        cycles = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        foreach (task_cnt[i])
            task_cnt[i] = 0;
        total_cnt = 0;
        entropy_q = 0;

        // empty total after reset, set boundaries, extremes
        dir = '{
            '{0,     0, 1, 1, 0, 0},
            '{31, 65535, 0, 1, 0, 65535},
            '{0,  65535, 0, 0, 0, 0},
            '{1,      1, 0, 0, 0, 0},
            '{31,     1, 0, 0, 0, 0},
            '{31, 65535, 0, 0, 0, 0},
            '{5,  65535, 1, 1, 0, 65535},
            '{5,  65535, 0, 0, 0, 0},
            '{5,      0, 0, 0, 0, 0},
            '{17,     0, 1, 1, 0, 0},
            '{17,     0, 0, 1, 0, 0},
            '{17,     3, 0, 1, 0, 3},
            '{18,     3, 0, 0, 0, 0},
            '{19,     6, 0, 0, 0, 0},
            '{20,     0, 0, 0, 0, 0},
            '{2,      1, 1, 1, 0, 1},
            '{3,  65535, 0, 0, 0, 0},
            '{2,      1, 0, 0, 0, 0},
            '{10, 21845, 0, 0, 0, 0},
            '{21, 43690, 0, 0, 0, 0},
            '{31, 65535, 0, 0, 0, 0}
        };

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[i])
        begin
            it.task_index   = dir[i].idx[4:0];
            it.added_count  = dir[i].add[15:0];
            it.first_of_set = dir[i].fos;
            tr.entropy_bits = dir[i].ent;
            tr.new_total    = dir[i].tot;
            tr.saturated    = 1'b0;
            send_item(it, dir[i].typed, tr);
        end

        hot = 0;
        for (int k = 0; k < RAND_ITEMS; k++)
        begin
            if (k == 150)
            begin
                send_idle_pct  = 66;
                recv_stall_pct = 0;
            end
            if (k == 300)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 66;
            end
            if (k == 450)
            begin
                send_idle_pct  = 12;
                recv_stall_pct = 12;
            end
            if (k == 320)
            begin
                in_valid <= 1'b0;
                wait (expected_results.size() == 0);
                @(posedge clk);
            end
            if ($urandom_range(19) == 0)
                hot = $urandom_range(31);
            it.first_of_set = ($urandom_range(24) == 0);
            it.task_index = ($urandom_range(2) == 0) ? 5'(hot) : 5'($urandom_range(31));
            case ($urandom_range(5))
                0: it.added_count = 16'hFFFF;
                1: it.added_count = 16'(0);
                2: it.added_count = 16'($urandom_range(15));
                default: it.added_count = 16'($urandom_range(65535));
            endcase
            send_item(it, 1'b0, tr);
        end
        in_valid <= 1'b0;

        wait (expected_results.size() == 0);
        repeat (DRAIN)
            @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
